FILE: hw/rtl/quadtree_preorder_tile_walker_assert.svh
// Assertion macros for the walker RTL
`ifndef QUADTREE_PREORDER_TILE_WALKER_ASSERT_SVH
`define QUADTREE_PREORDER_TILE_WALKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define QPTW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define QPTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/qptw_pkg.sv
package qptw_pkg;

  localparam int MAX_LEVEL = 24;
  localparam int DIG_W     = 2;
  localparam int LVL_W     = 5;
  localparam int COORD_W   = 24;
  localparam int PATH_W    = MAX_LEVEL * DIG_W;

  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_LOAD    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DONE   = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  localparam logic [DIG_W-1:0] DIG_LAST = 2'd3;

  // Broadcast to every cell in the chain
  typedef struct packed {
    logic step;   // move to next sibling / ancestor sibling
    logic load;   // overwrite with start tile
  } cell_ctrl_t;

  // Quadrant digit from (col bit, row bit): 0=(0,0) 1=(1,0) 2=(1,1) 3=(0,1)
  function automatic logic [DIG_W-1:0] quad_of(input logic c, input logic r);
    logic [DIG_W-1:0] q;
    case ({c, r})
      2'b00:   q = 2'd0;
      2'b01:   q = 2'd3;
      2'b10:   q = 2'd1;
      2'b11:   q = 2'd2;
      default: q = 2'd0;
    endcase
    return q;
  endfunction

  function automatic logic row_of(input logic [DIG_W-1:0] d);
    return d[1];
  endfunction

  function automatic logic col_of(input logic [DIG_W-1:0] d);
    return d[1] ^ d[0];
  endfunction

endpackage

FILE: hw/rtl/qptw_if.sv
// Input channel: one command beat
interface qptw_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [qptw_pkg::LVL_W-1:0]    start_level;
  logic [qptw_pkg::COORD_W-1:0]  start_row;
  logic [qptw_pkg::COORD_W-1:0]  start_col;

  modport source (output valid, opcode, start_level, start_row, start_col, input ready);
  modport sink   (input valid, opcode, start_level, start_row, start_col, output ready);
endinterface

// Output channel: one tile beat
interface qptw_out_if;
  logic                          valid;
  logic                          ready;
  logic [qptw_pkg::PATH_W-1:0]   path_digits;
  logic [qptw_pkg::LVL_W-1:0]    cur_level;
  logic [qptw_pkg::COORD_W-1:0]  cur_row;
  logic [qptw_pkg::COORD_W-1:0]  cur_col;
  logic [1:0]                    status;

  modport source (output valid, path_digits, cur_level, cur_row, cur_col, status,
                  input ready);
  modport sink   (input valid, path_digits, cur_level, cur_row, cur_col, status,
                  output ready);
endinterface

FILE: hw/rtl/qptw_cell.sv
// One level of the path: holds a quadrant digit, passes the "all deeper
// digits are 3" flag up towards the root.
module qptw_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  qptw_pkg::cell_ctrl_t        ctrl_i,
  input  logic                        active_i,   // level is within current depth
  input  logic                        ld_en_i,    // level is within load depth
  input  logic                        ld_row_i,
  input  logic                        ld_col_i,
  input  logic                        strip_i,    // from deeper neighbour
  output logic                        strip_o,    // to shallower neighbour
  output logic                        target_o,   // this digit gets incremented
  output logic [qptw_pkg::DIG_W-1:0]  digit_o,
  output logic                        row_o,
  output logic                        col_o
);

  logic [qptw_pkg::DIG_W-1:0] digit_q, digit_d;
  logic                       is_last;
  logic                       drop;

  assign is_last  = (digit_q == qptw_pkg::DIG_LAST);
  assign strip_o  = !active_i || (is_last && strip_i);
  assign target_o = active_i && strip_i && !is_last;
  assign drop     = active_i && strip_i && is_last;

  // next digit
  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.load) begin
      digit_d = ld_en_i ? qptw_pkg::quad_of(ld_col_i, ld_row_i) : '0;
    end else if (ctrl_i.step) begin
      if (target_o) begin
        digit_d = digit_q + qptw_pkg::DIG_W'(1);
      end else if (drop) begin
        digit_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;
  assign row_o   = active_i && qptw_pkg::row_of(digit_q);
  assign col_o   = active_i && qptw_pkg::col_of(digit_q);

endmodule

FILE: hw/rtl/quadtree_preorder_tile_walker.sv
// Quadtree preorder tile walker.
// in_i carries command beats: opcode 0 advances to the next preorder node,
// opcode 1 loads a start tile from start_level/start_row/start_col.
// out_o gives one beat per command: the quadrant path (level one in the
// top bits), level, row, column and a status (ok, walk finished, load
// rejected; the node is unchanged for the last two).
// cfg_we_i/cfg_wdata_i write the depth cap, the deepest level generated;
// write it only while no command is outstanding.
// Latency: the result beat is valid the cycle after its command is taken.
// Throughput: one command per cycle; the path sits in a row of 24 digit
// cells and the next sibling is found by a single ripple pass up the row.
// The result is read straight off the walker state; while the receiver stalls the
// state holds and in_i.ready stays low until that beat is taken.
// Reset puts the walker at the root with an all-zero path and a depth cap of 24.
`include "quadtree_preorder_tile_walker_assert.svh"

module quadtree_preorder_tile_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  qptw_in_if.sink                     in_i,
  qptw_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [qptw_pkg::LVL_W-1:0]  cfg_wdata_i
);

  localparam int N = qptw_pkg::MAX_LEVEL;

  logic [qptw_pkg::LVL_W-1:0]   depth_cap_q;
  logic [qptw_pkg::LVL_W-1:0]   depth_q, depth_d;
  logic [1:0]                   status_q, status_d;
  logic                         out_valid_q;

  logic                         accept;
  logic [qptw_pkg::LVL_W-1:0]   limit;
  logic                         descend, found, reject, is_load;
  qptw_pkg::cell_ctrl_t         ctrl;
  logic [qptw_pkg::LVL_W-1:0]   step_depth;
  logic [31:0]                  ld_row_ext, ld_col_ext;

  logic [N-1:0]                 active, ld_en, ld_row, ld_col, target, row_b, col_b;
  logic [N:0]                   strip;
  logic [qptw_pkg::DIG_W-1:0]   digit [N];
  logic [qptw_pkg::COORD_W-1:0] row_full, col_full;
  logic [qptw_pkg::LVL_W-1:0]   shamt;

  assign accept  = in_i.valid && in_i.ready;
  assign is_load = (in_i.opcode == qptw_pkg::OP_LOAD);

  // walk limit and command decode
  assign limit   = (depth_cap_q < qptw_pkg::LVL_W'(N)) ? depth_cap_q : qptw_pkg::LVL_W'(N);
  assign descend = (depth_q < limit);
  assign found   = !strip[0];
  assign reject  = (in_i.start_level > depth_cap_q) ||
                   (in_i.start_level > qptw_pkg::LVL_W'(N));

  assign ctrl.load = accept && is_load && !reject;
  assign ctrl.step = accept && !is_load && !descend && found;

  assign ld_row_ext = {{(32 - qptw_pkg::COORD_W){1'b0}}, in_i.start_row};
  assign ld_col_ext = {{(32 - qptw_pkg::COORD_W){1'b0}}, in_i.start_col};

  // row of cells, deepest cell sees an open strip flag
  assign strip[N] = 1'b1;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [qptw_pkg::LVL_W-1:0] sh;
    assign active[i] = (qptw_pkg::LVL_W'(i) < depth_q);
    assign ld_en[i]  = (qptw_pkg::LVL_W'(i) < in_i.start_level);
    assign sh        = in_i.start_level - qptw_pkg::LVL_W'(i + 1);
    assign ld_row[i] = ld_row_ext[sh];
    assign ld_col[i] = ld_col_ext[sh];

    qptw_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .active_i (active[i]),
      .ld_en_i  (ld_en[i]),
      .ld_row_i (ld_row[i]),
      .ld_col_i (ld_col[i]),
      .strip_i  (strip[i+1]),
      .strip_o  (strip[i]),
      .target_o (target[i]),
      .digit_o  (digit[i]),
      .row_o    (row_b[i]),
      .col_o    (col_b[i])
    );

    assign row_full[qptw_pkg::COORD_W-1-i] = row_b[i];
    assign col_full[qptw_pkg::COORD_W-1-i] = col_b[i];
    assign out_o.path_digits[qptw_pkg::PATH_W-1-qptw_pkg::DIG_W*i -: qptw_pkg::DIG_W] =
      digit[i];
  end

  // level of the incremented digit (target is one-hot when found)
  always_comb begin
    step_depth = '0;
    for (int i = 0; i < N; i++) begin
      step_depth = step_depth | (target[i] ? qptw_pkg::LVL_W'(i + 1) : '0);
    end
  end

  // next depth and status
  always_comb begin
    depth_d  = depth_q;
    status_d = status_q;
    if (accept) begin
      if (is_load) begin
        if (reject) begin
          status_d = qptw_pkg::ST_REJECT;
        end else begin
          depth_d  = in_i.start_level;
          status_d = qptw_pkg::ST_OK;
        end
      end else if (descend) begin
        depth_d  = depth_q + qptw_pkg::LVL_W'(1);
        status_d = qptw_pkg::ST_OK;
      end else if (found) begin
        depth_d  = step_depth;
        status_d = qptw_pkg::ST_OK;
      end else begin
        status_d = qptw_pkg::ST_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_cap_q <= qptw_pkg::LVL_W'(24);
      depth_q     <= '0;
      status_q    <= qptw_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        depth_cap_q <= cfg_wdata_i;
      end
      depth_q  <= depth_d;
      status_q <= status_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output beat is read straight off the state, which holds while stalled
  assign shamt           = qptw_pkg::LVL_W'(qptw_pkg::COORD_W) - depth_q;
  assign in_i.ready      = !out_valid_q || out_o.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.cur_level = depth_q;
  assign out_o.cur_row   = row_full >> shamt;
  assign out_o.cur_col   = col_full >> shamt;
  assign out_o.status    = status_q;

  // checks
  `QPTW_ASSERT_NOW(a_depth_range, clk_i, rst_ni, 1'b1, depth_q <= qptw_pkg::LVL_W'(N), "depth out of range")
  `QPTW_ASSERT_NOW(a_target_onehot, clk_i, rst_ni, 1'b1, $onehot0(target), "several digits targeted")
  `QPTW_ASSERT_NEXT(a_reject_holds, clk_i, rst_ni, accept && is_load && reject, $stable(depth_q) && status_q == qptw_pkg::ST_REJECT, "rejected load moved the node")
  `QPTW_ASSERT_NEXT(a_done_holds, clk_i, rst_ni, accept && !is_load && !descend && !found, $stable(depth_q) && status_q == qptw_pkg::ST_DONE, "finished walk moved the node")

endmodule
